>>> hdl/abc_pkg.sv
// shared types and constants of the accel-brake ecn marker
`timescale 1ns / 1ps
package abc_pkg;

  localparam int unsigned DIV_BITS = 49;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS + 1);

  localparam logic [19:0] TOKEN_ONE = 20'd65536;
  localparam logic [19:0] TOKEN_CAP = 20'd327680;

  localparam logic [1:0] ECN_NOT_ECT = 2'd0;
  localparam logic [1:0] ECN_CE      = 2'd3;

  localparam logic       OP_PACKET = 1'b0;
  localparam logic       OP_TICK   = 1'b1;

  localparam logic [2:0] CFG_LINK_BW  = 3'd0;
  localparam logic [2:0] CFG_UTIL     = 3'd1;
  localparam logic [2:0] CFG_SLOPE    = 3'd2;
  localparam logic [2:0] CFG_REF      = 3'd3;
  localparam logic [2:0] CFG_INTERVAL = 3'd4;

  typedef enum logic [1:0] {
    DIV_SEL_CUT  = 2'd0,
    DIV_SEL_RATE = 2'd1,
    DIV_SEL_TICK = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     accept;
    logic     load_full;
    logic     div_start;
    div_sel_e div_sel;
    logic     tgt_direct;
    logic     tgt_cut;
    logic     f_one;
    logic     f_load;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic rate_zero;
    logic over_ref;
    logic slope_zero;
    logic interval_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/abc_div.sv
// bit-serial restoring divider, 49-bit dividend by 32-bit divisor
`timescale 1ns / 1ps
module abc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [abc_pkg::DIV_BITS-1:0]  dividend_i,
  input  logic [31:0]                   divisor_i,
  output logic [abc_pkg::DIV_BITS-1:0]  quotient_o,
  output logic                          rem_nz_o,
  output logic                          done_o
);

  logic [abc_pkg::DIV_BITS-1:0]  quo_q;
  logic [31:0]                   rem_q;
  logic [31:0]                   dsr_q;
  logic [abc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [32:0]                   trial;
  logic                          ge;
  logic [32:0]                   diff;

  assign trial = {rem_q, quo_q[abc_pkg::DIV_BITS-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= abc_pkg::DIV_CNT_W'(abc_pkg::DIV_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == abc_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[abc_pkg::DIV_BITS-2:0], ge};
      rem_q <= ge ? diff[31:0] : trial[31:0];
    end
  end

  assign quotient_o = quo_q;
  assign rem_nz_o   = rem_q != 32'd0;
  assign done_o     = done_q;

endmodule

>>> hdl/abc_dp.sv
// datapath: configuration, marker state, divider operands and result register
`timescale 1ns / 1ps
module abc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                opcode_i,
  input  logic [31:0]         queue_delay_i,
  input  logic [1:0]          ecn_in_i,
  input  logic [15:0]         packet_length_i,
  input  abc_pkg::cmd_t       cmd_i,
  output abc_pkg::sts_t       sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          ecn_out_o,
  output logic                marked_o,
  output logic [18:0]         token_level_o,
  output logic [31:0]         drain_rate_o,
  output logic [31:0]         mark_total_o
);

  logic [31:0] bw_q, slope_q, ref_q;
  logic [8:0]  util_q;
  logic [15:0] ival_q;

  logic        op_q;
  logic [31:0] delay_q;
  logic [1:0]  ecn_q;
  logic [15:0] len_q;

  logic [18:0] token_q;
  logic [39:0] drained_q;
  logic [31:0] rate_q, last_q, markcnt_q;

  logic [48:0] full_q, target_q;
  logic [16:0] f_q;

  logic        out_valid_q;
  logic [1:0]  ecn_out_q;
  logic        marked_q;
  logic [18:0] token_level_q;
  logic [31:0] drain_rate_q, mark_total_q;

  logic [48:0] div_dividend, div_quo, cut, target_cut;
  logic [31:0] div_divisor, excess_hi;
  logic        div_rem_nz, div_done;
  logic [40:0] full_prod;
  logic [16:0] f_rate;

  logic [19:0] tok_sum, tok_cap, tok_new;
  logic        pass, mark;
  logic [31:0] c32, rate_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q    <= 32'd1;
      util_q  <= 9'd1;
      slope_q <= 32'd10000000;
      ref_q   <= 32'd10000000;
      ival_q  <= 16'd10;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        abc_pkg::CFG_LINK_BW:  bw_q    <= cfg_data_i;
        abc_pkg::CFG_UTIL:     util_q  <= cfg_data_i[8:0];
        abc_pkg::CFG_SLOPE:    slope_q <= cfg_data_i;
        abc_pkg::CFG_REF:      ref_q   <= cfg_data_i;
        abc_pkg::CFG_INTERVAL: ival_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared divider
  assign excess_hi = last_q - ref_q;
  always_comb begin
    case (cmd_i.div_sel)
      abc_pkg::DIV_SEL_CUT: begin
        div_dividend = {1'b0, excess_hi, 16'd0};
        div_divisor  = slope_q;
      end
      abc_pkg::DIV_SEL_RATE: begin
        div_dividend = target_q;
        div_divisor  = rate_q;
      end
      abc_pkg::DIV_SEL_TICK: begin
        div_dividend = {1'b0, drained_q, 8'd0};
        div_divisor  = {16'd0, ival_q};
      end
      default: begin
        div_dividend = target_q;
        div_divisor  = rate_q;
      end
    endcase
  end

  abc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .rem_nz_o   (div_rem_nz),
    .done_o     (div_done)
  );

  assign full_prod  = {32'd0, util_q} * {9'd0, bw_q};
  assign cut        = div_quo + {48'd0, div_rem_nz};
  assign target_cut = (full_q > cut) ? full_q - cut : 49'd0;
  assign f_rate     = (div_quo[48:17] != 32'd0) ? 17'd65536 : {1'b0, div_quo[16:1]};

  // packet update
  assign tok_sum = {1'b0, token_q} + {3'b0, f_q};
  assign tok_cap = (tok_sum > abc_pkg::TOKEN_CAP) ? abc_pkg::TOKEN_CAP : tok_sum;
  assign pass    = (tok_cap > abc_pkg::TOKEN_ONE) && (ecn_q != abc_pkg::ECN_CE);
  assign tok_new = pass ? tok_cap - abc_pkg::TOKEN_ONE : tok_cap;
  assign mark    = !pass && (ecn_q != abc_pkg::ECN_NOT_ECT);

  // tick update, saturated measurement then jump-up or 1/8 ewma
  assign c32 = (div_quo[48:32] != 17'd0) ? 32'hFFFF_FFFF : div_quo[31:0];
  assign rate_new = ((rate_q == 32'd0) || (c32 > rate_q)) ? c32
                  : (rate_q - {3'd0, rate_q[31:3]}) + {3'd0, c32[31:3]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= opcode_i;
      delay_q <= queue_delay_i;
      ecn_q   <= ecn_in_i;
      len_q   <= packet_length_i;
    end
    if (cmd_i.load_full) full_q <= {full_prod, 8'd0};
    if (cmd_i.tgt_direct) target_q <= (last_q > ref_q) ? 49'd0 : full_q;
    else if (cmd_i.tgt_cut) target_q <= target_cut;
    if (cmd_i.f_one) f_q <= 17'd65536;
    else if (cmd_i.f_load) f_q <= f_rate;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q     <= '0;
      drained_q   <= '0;
      rate_q      <= '0;
      last_q      <= '0;
      markcnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (op_q == abc_pkg::OP_PACKET) begin
          token_q   <= tok_new[18:0];
          drained_q <= drained_q + {24'd0, len_q};
          last_q    <= delay_q;
          if (mark) markcnt_q <= markcnt_q + 32'd1;
        end else if (ival_q != 16'd0) begin
          rate_q    <= rate_new;
          drained_q <= '0;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (op_q == abc_pkg::OP_PACKET) begin
        ecn_out_q     <= mark ? abc_pkg::ECN_CE : ecn_q;
        marked_q      <= mark;
        token_level_q <= tok_new[18:0];
        drain_rate_q  <= rate_q;
        mark_total_q  <= mark ? markcnt_q + 32'd1 : markcnt_q;
      end else begin
        ecn_out_q     <= abc_pkg::ECN_NOT_ECT;
        marked_q      <= 1'b0;
        token_level_q <= token_q;
        drain_rate_q  <= (ival_q != 16'd0) ? rate_new : rate_q;
        mark_total_q  <= markcnt_q;
      end
    end
  end

  assign sts_o.is_tick       = op_q == abc_pkg::OP_TICK;
  assign sts_o.rate_zero     = rate_q == 32'd0;
  assign sts_o.over_ref      = last_q > ref_q;
  assign sts_o.slope_zero    = slope_q == 32'd0;
  assign sts_o.interval_zero = ival_q == 16'd0;
  assign sts_o.div_done      = div_done;
  assign sts_o.out_free      = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign ecn_out_o     = ecn_out_q;
  assign marked_o      = marked_q;
  assign token_level_o = token_level_q;
  assign drain_rate_o  = drain_rate_q;
  assign mark_total_o  = mark_total_q;

endmodule

>>> hdl/abc_ctrl.sv
// controller state machine sequencing the datapath and divider
`timescale 1ns / 1ps
module abc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  abc_pkg::sts_t sts_i,
  output abc_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_SEL  = 8'b0000_0100,
    S_CUT  = 8'b0000_1000,
    S_TGT  = 8'b0001_0000,
    S_RATE = 8'b0010_0000,
    S_TDIV = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = abc_pkg::DIV_SEL_RATE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.load_full = 1'b1;
        state_d = S_SEL;
      end
      S_SEL: begin
        if (sts_i.is_tick) begin
          if (sts_i.interval_zero) begin
            state_d = S_DONE;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = abc_pkg::DIV_SEL_TICK;
            state_d = S_TDIV;
          end
        end else if (sts_i.rate_zero) begin
          cmd_o.f_one = 1'b1;
          state_d = S_DONE;
        end else if (sts_i.over_ref && !sts_i.slope_zero) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = abc_pkg::DIV_SEL_CUT;
          state_d = S_CUT;
        end else begin
          cmd_o.tgt_direct = 1'b1;
          state_d = S_TGT;
        end
      end
      S_CUT: begin
        if (sts_i.div_done) begin
          cmd_o.tgt_cut = 1'b1;
          state_d = S_TGT;
        end
      end
      S_TGT: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = abc_pkg::DIV_SEL_RATE;
        state_d = S_RATE;
      end
      S_RATE: begin
        if (sts_i.div_done) begin
          cmd_o.f_load = 1'b1;
          state_d = S_DONE;
        end
      end
      S_TDIV: begin
        if (sts_i.div_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

>>> hdl/accel_brake_ecn_marker.sv
// top level of the accel-brake ecn marker
`timescale 1ns / 1ps
// the 49-step 1-bit-a-cycle divider runs twice for a packet over the reference delay,
// for the cut and then the rate, once for one at or below it (or with a zero slope),
// and not for a packet with no rate yet; once for a tick, not for a zero-interval tick
// throughput: one transaction at a time, next accepted the cycle after the result
// register is loaded, even while that result still waits on the output side
// reset: asynchronous active low, clears marker state and loads register defaults
module accel_brake_ecn_marker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input transactions
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] queue_delay_i,
  input  logic [1:0]  ecn_in_i,
  input  logic [15:0] packet_length_i,
  // result transactions
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  ecn_out_o,
  output logic        marked_o,
  output logic [18:0] token_level_o,
  output logic [31:0] drain_rate_o,
  output logic [31:0] mark_total_o
);

  abc_pkg::cmd_t cmd;
  abc_pkg::sts_t sts;

  // registers are always writable, writes must only come while idle, not enforced here
  assign cfg_ready_o = 1'b1;

  abc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  abc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .queue_delay_i   (queue_delay_i),
    .ecn_in_i        (ecn_in_i),
    .packet_length_i (packet_length_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ecn_out_o       (ecn_out_o),
    .marked_o        (marked_o),
    .token_level_o   (token_level_o),
    .drain_rate_o    (drain_rate_o),
    .mark_total_o    (mark_total_o)
  );

`ifndef ASSERT_OFF
  // token bucket never exceeds its cap
  a_token_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, token_level_o} <= abc_pkg::TOKEN_CAP))
    else $error("token level above cap");

  // a counted mark always leaves as ce
  a_mark_ce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && marked_o) |-> (ecn_out_o == abc_pkg::ECN_CE))
    else $error("marked packet not ce");

  // an accepted transaction raises the input stall
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");
`endif

endmodule
